// ===== src/mvd_pkg.sv =====
// Package: shared constants, register indexes and sequencer states of the divergence block.
`timescale 1ns / 1ps
`default_nettype none
package mvd_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W        = 32;
	localparam int CFG_W         = 31;
	localparam int SUM_W         = 64;
	localparam int SQ_IN_W       = 64;
	localparam int SQ_OUT_W      = 32;

	localparam logic [CFG_W-1:0] COEF_RESET   = 31'd65536;
	localparam logic [CFG_W-1:0] RADIUS_RESET = 31'd137626;
	localparam logic [SUM_W-1:0] SMAX64       = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [SUM_W-1:0] SMIN64       = 64'h8000_0000_0000_0001;

	localparam logic REG_COEF   = 1'b0;
	localparam logic REG_RADIUS = 1'b1;

	localparam logic OP_CENTRE    = 1'b0;
	localparam logic OP_NEIGHBOUR = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PROD,
		ST_CHECK,
		ST_SQRT,
		ST_RANGE,
		ST_WDIV,
		ST_RDIV,
		ST_WMUL,
		ST_TACC,
		ST_FSTART,
		ST_FDIV,
		ST_FOUT
	} state_t;

endpackage
`default_nettype wire

// ===== src/mvd_ifs.sv =====
// Interfaces: input and result channels of the divergence block.
`timescale 1ns / 1ps
`default_nettype none
interface mvd_in_if;
	import mvd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     operation;
	logic signed [DATA_W-1:0] pos_x;
	logic signed [DATA_W-1:0] pos_y;
	logic signed [DATA_W-1:0] pos_z;
	logic signed [DATA_W-1:0] field_x;
	logic signed [DATA_W-1:0] field_y;
	logic signed [DATA_W-1:0] field_z;
	logic        [CFG_W-1:0]  base_density;
	logic                     last;

	modport source (output valid, operation, pos_x, pos_y, pos_z, field_x, field_y, field_z,
		base_density, last, input ready);
	modport sink (input valid, operation, pos_x, pos_y, pos_z, field_x, field_y, field_z,
		base_density, last, output ready);
endinterface

interface mvd_out_if;
	import mvd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] divergence;
	logic                     zero_distance_seen;
	logic                     saturated;

	modport source (output valid, divergence, zero_distance_seen, saturated, input ready);
	modport sink (input valid, divergence, zero_distance_seen, saturated, output ready);
endinterface
`default_nettype wire

// ===== src/mvd_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mvd_div #(
	parameter int NUM_W = 80,
	parameter int DEN_W = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic                  done,
	output logic      [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             ge;

	// trial subtract of the shifted partial remainder
	assign rem_sh = {rem_q, quo_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end else if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

// ===== src/mvd_sqrt.sv =====
// Integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mvd_sqrt
	import mvd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SQ_IN_W-1:0]  rad,
	output logic                     done,
	output logic      [SQ_OUT_W-1:0] root
);
	localparam int REM_W = SQ_OUT_W + 2;
	localparam int CNT_W = $clog2(SQ_OUT_W);

	logic [SQ_IN_W-1:0]  v_q;
	logic [REM_W-1:0]    rem_q;
	logic [SQ_OUT_W-1:0] root_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [REM_W+1:0]    rem_sh;
	logic [REM_W+1:0]    trial;
	logic                ge;

	assign rem_sh = {rem_q, v_q[SQ_IN_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SQ_OUT_W - 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			v_q    <= {v_q[SQ_IN_W-3:0], 2'b00};
			rem_q  <= ge ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
			root_q <= {root_q[SQ_OUT_W-2:0], ge};
		end else if (start) begin
			v_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

// ===== src/mps_velocity_divergence_top.sv =====
// Top level: MPS divergence of a vector field at one centre particle.
//
// Input channel in_ch carries one word per particle. operation = centre loads the
// centre position, field and base density and clears the sum and both flags;
// operation = neighbour adds one kernel-weighted term. A word with last set
// produces one result word on out_ch after its own work is done.
// Config port: cfg_we writes cfg_data into register cfg_index (0 coefficient,
// 1 support radius); write it only while the block is idle, which the block
// itself does not enforce. A neighbour runs products and checks, a square root,
// two divisions and a wide multiply and accumulate; neighbours that are coincident
// or outside the radius leave early. A word with last adds one division and one
// wide multiply. The divider, 64 + FRAC_BITS quotient bits wide, and the 32x32
// multiplier are shared between these steps.
// in_ch.ready is high only between words. The result sits in an output register;
// a stalled receiver holds it, and the next word is taken meanwhile, but a further
// result waits until the register is free. Reset clears the state to a zero centre
// with unit density and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module mps_velocity_divergence_top #(
	parameter int FRAC_BITS = mvd_pkg::FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	mvd_in_if.sink                        in_ch,
	mvd_out_if.source                     out_ch,
	input  wire logic                     cfg_we,
	input  wire logic                     cfg_index,
	input  wire logic [mvd_pkg::CFG_W-1:0] cfg_data
);
	import mvd_pkg::*;

	localparam int NW = SUM_W + FRAC_BITS;

	state_t state_q, state_d;

	// configuration and particle state
	logic        [CFG_W-1:0]  coef_q, rad_q, cbase_q;
	logic signed [DATA_W-1:0] cpos_q [3];
	logic signed [DATA_W-1:0] cfld_q [3];
	logic signed [DATA_W-1:0] npos_q [3];
	logic signed [DATA_W-1:0] nfld_q [3];
	logic signed [SUM_W-1:0]  sum_q, dot_q;
	logic        [SUM_W-1:0]  d2_q;
	logic                     zflag_q, oflag_q, last_q;

	// sequencing and shared arithmetic
	logic [2:0]         pc_q, pidx_q;
	logic               fin_q;
	logic [SUM_W-1:0]   mop_a_q, mop_b_q;
	logic [2*SUM_W-1:0] acc_q;
	logic [SUM_W-1:0]   prod_s1;
	logic [DATA_W-1:0]  mul_a, mul_b;

	// result register
	logic                     out_valid_q, zs_out_q, sat_out_q;
	logic signed [DATA_W-1:0] div_out_q;

	// divider and square root
	logic              div_start, div_busy, div_done;
	logic [NW-1:0]     div_num, div_quo;
	logic [SUM_W-1:0]  div_den;
	logic              sq_start, sq_done;
	logic [SQ_OUT_W-1:0] sq_root;

	mvd_div #(.NUM_W(NW), .DEN_W(SUM_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quo(div_quo)
	);

	mvd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .rad(d2_q << FRAC_BITS),
		.done(sq_done), .root(sq_root)
	);

	// neighbour minus centre differences and their magnitudes
	logic [DATA_W:0]   dp [3];
	logic [DATA_W:0]   df [3];
	logic [DATA_W-1:0] mp [3];
	logic [DATA_W-1:0] mf [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dp[k] = {npos_q[k][DATA_W-1], npos_q[k]} - {cpos_q[k][DATA_W-1], cpos_q[k]};
			df[k] = {nfld_q[k][DATA_W-1], nfld_q[k]} - {cfld_q[k][DATA_W-1], cfld_q[k]};
			mp[k] = dp[k][DATA_W] ? DATA_W'(-dp[k]) : dp[k][DATA_W-1:0];
			mf[k] = df[k][DATA_W] ? DATA_W'(-df[k]) : df[k][DATA_W-1:0];
		end
	end

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_PROD && pc_q < 3'd6) begin
			mul_b = mp[pc_q[2:1]];
			mul_a = pc_q[0] ? mp[pc_q[2:1]] : mf[pc_q[2:1]];
		end else if (state_q == ST_WMUL) begin
			mul_a = pidx_q[1] ? mop_a_q[SUM_W-1:DATA_W] : mop_a_q[DATA_W-1:0];
			mul_b = pidx_q[0] ? mop_b_q[SUM_W-1:DATA_W] : mop_b_q[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= SUM_W'(mul_a) * SUM_W'(mul_b);
	end

	// accumulation helpers
	logic [2:0]         pc_prev, pidx_prev;
	logic [SUM_W-1:0]   prod_sh;
	logic [2*SUM_W-1:0] pp_sh;
	assign pc_prev   = pc_q - 3'd1;
	assign pidx_prev = pidx_q - 3'd1;
	assign prod_sh   = prod_s1 >> FRAC_BITS;
	always_comb begin
		case (pidx_prev[1:0])
			2'd0:    pp_sh = {{SUM_W{1'b0}}, prod_s1};
			2'd3:    pp_sh = {prod_s1, {SUM_W{1'b0}}};
			default: pp_sh = {{DATA_W{1'b0}}, prod_s1, {DATA_W{1'b0}}};
		endcase
	end

	// term and sum update
	logic [SUM_W-1:0]   term;
	logic               term_sat;
	logic signed [SUM_W:0] sum_new;
	logic [SUM_W-1:0]   sum_upd;
	logic               sum_sat;
	always_comb begin
		term_sat = acc_q[2*SUM_W-1:SUM_W] != '0;
		term     = term_sat ? SMAX64 : (acc_q[SUM_W-1:0] >> FRAC_BITS);
		if (dot_q[SUM_W-1]) begin
			sum_new = {sum_q[SUM_W-1], sum_q} - {1'b0, term};
			sum_sat = sum_new < $signed({1'b1, SMIN64});
			sum_upd = sum_sat ? SMIN64 : sum_new[SUM_W-1:0];
		end else begin
			sum_new = {sum_q[SUM_W-1], sum_q} + {1'b0, term};
			sum_sat = sum_new > $signed({1'b0, SMAX64});
			sum_upd = sum_sat ? SMAX64 : sum_new[SUM_W-1:0];
		end
	end

	// final scaling and clamp
	logic [2*SUM_W-1:0] fin_v, fin_lim;
	logic               fin_sat;
	logic [DATA_W-1:0]  fin_r;
	always_comb begin
		fin_v   = acc_q >> FRAC_BITS;
		fin_lim = sum_q[SUM_W-1] ? (2*SUM_W)'(32'h8000_0000) : (2*SUM_W)'(32'h7FFF_FFFF);
		fin_sat = fin_v > fin_lim;
		fin_r   = fin_sat ? fin_lim[DATA_W-1:0] : fin_v[DATA_W-1:0];
	end

	logic [SUM_W-1:0] dot_mag, sum_mag, ratio_q, w_val;
	logic             ratio_sat, far, near_zero;
	assign dot_mag   = dot_q[SUM_W-1] ? SUM_W'(-dot_q) : SUM_W'(dot_q);
	assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign ratio_sat = div_quo[NW-1:SUM_W-1] != '0;
	assign ratio_q   = ratio_sat ? SMAX64 : div_quo[SUM_W-1:0];
	assign w_val     = div_quo[SUM_W-1:0] - (SUM_W'(1) << FRAC_BITS);
	assign far       = (d2_q >> (SUM_W - FRAC_BITS)) != '0;
	assign near_zero = (sq_root == '0) || ({1'b0, sq_root} >= {2'b00, rad_q});

	logic   out_free;
	state_t st_end;
	assign out_free = !out_valid_q || out_ch.ready;
	assign st_end   = last_q ? ST_FSTART : ST_IDLE;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// next state and unit starts
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		sq_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.operation == OP_NEIGHBOUR) state_d = ST_PROD;
					else if (in_ch.last)                 state_d = ST_FSTART;
				end
			end
			ST_PROD:  if (pc_q == 3'd6) state_d = ST_CHECK;
			ST_CHECK: begin
				if (d2_q == '0 || far) begin
					state_d = st_end;
				end else begin
					sq_start = 1'b1;
					state_d  = ST_SQRT;
				end
			end
			ST_SQRT:  if (sq_done) state_d = ST_RANGE;
			ST_RANGE: begin
				if (near_zero) begin
					state_d = st_end;
				end else begin
					div_start = 1'b1;
					div_num   = NW'(rad_q) << FRAC_BITS;
					div_den   = SUM_W'(sq_root);
					state_d   = ST_WDIV;
				end
			end
			ST_WDIV: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num   = NW'(dot_mag) << FRAC_BITS;
					div_den   = d2_q;
					state_d   = ST_RDIV;
				end
			end
			ST_RDIV:   if (div_done) state_d = ST_WMUL;
			ST_WMUL:   if (pidx_q == 3'd4) state_d = fin_q ? ST_FOUT : ST_TACC;
			ST_TACC:   state_d = st_end;
			ST_FSTART: begin
				if (!div_busy) begin
					div_start = 1'b1;
					div_num   = NW'(coef_q) << FRAC_BITS;
					div_den   = (cbase_q == '0) ? SUM_W'(1) : SUM_W'(cbase_q);
					state_d   = ST_FDIV;
				end
			end
			ST_FDIV: if (div_done) state_d = ST_WMUL;
			ST_FOUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q      <= COEF_RESET;
			rad_q       <= RADIUS_RESET;
			cbase_q     <= CFG_W'(1) << FRAC_BITS;
			sum_q       <= '0;
			zflag_q     <= 1'b0;
			oflag_q     <= 1'b0;
			out_valid_q <= 1'b0;
			zs_out_q    <= 1'b0;
			sat_out_q   <= 1'b0;
			div_out_q   <= '0;
			last_q      <= 1'b0;
			fin_q       <= 1'b0;
			pc_q        <= '0;
			pidx_q      <= '0;
			for (int k = 0; k < 3; k++) begin
				cpos_q[k] <= '0;
				cfld_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COEF:   coef_q <= cfg_data;
					REG_RADIUS: rad_q  <= cfg_data;
				endcase
			end
			// result word valid: set on a new result, cleared when taken
			if (state_q == ST_FOUT && out_free) out_valid_q <= 1'b1;
			else if (out_ch.ready)              out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						last_q <= in_ch.last;
						pc_q   <= '0;
						if (in_ch.operation == OP_CENTRE) begin
							cpos_q[0] <= in_ch.pos_x;
							cpos_q[1] <= in_ch.pos_y;
							cpos_q[2] <= in_ch.pos_z;
							cfld_q[0] <= in_ch.field_x;
							cfld_q[1] <= in_ch.field_y;
							cfld_q[2] <= in_ch.field_z;
							cbase_q   <= in_ch.base_density;
							sum_q     <= '0;
							zflag_q   <= 1'b0;
							oflag_q   <= 1'b0;
						end
					end
				end
				ST_PROD:  pc_q <= pc_q + 3'd1;
				ST_CHECK: if (d2_q == '0) zflag_q <= 1'b1;
				ST_RDIV: begin
					if (div_done) begin
						fin_q  <= 1'b0;
						pidx_q <= '0;
						if (ratio_sat) oflag_q <= 1'b1;
					end
				end
				ST_WMUL:  pidx_q <= pidx_q + 3'd1;
				ST_TACC: begin
					sum_q <= sum_upd;
					if (term_sat || sum_sat) oflag_q <= 1'b1;
				end
				ST_FDIV: begin
					if (div_done) begin
						fin_q  <= 1'b1;
						pidx_q <= '0;
					end
				end
				ST_FOUT: begin
					if (out_free) begin
						zs_out_q    <= zflag_q;
						sat_out_q   <= oflag_q | fin_sat;
						div_out_q   <= sum_q[SUM_W-1] ? DATA_W'(-fin_r) : fin_r;
						if (fin_sat) oflag_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				npos_q[0] <= in_ch.pos_x;
				npos_q[1] <= in_ch.pos_y;
				npos_q[2] <= in_ch.pos_z;
				nfld_q[0] <= in_ch.field_x;
				nfld_q[1] <= in_ch.field_y;
				nfld_q[2] <= in_ch.field_z;
				dot_q     <= '0;
				d2_q      <= '0;
			end
			ST_PROD: begin
				if (pc_q != '0) begin
					if (pc_prev[0]) begin
						d2_q <= d2_q + prod_sh;
					end else if (dp[pc_prev[2:1]][DATA_W] ^ df[pc_prev[2:1]][DATA_W]) begin
						dot_q <= dot_q - $signed(prod_sh);
					end else begin
						dot_q <= dot_q + $signed(prod_sh);
					end
				end
			end
			ST_WDIV: if (div_done) mop_b_q <= w_val;
			ST_RDIV: begin
				if (div_done) begin
					mop_a_q <= ratio_q;
					acc_q   <= '0;
				end
			end
			ST_FDIV: begin
				if (div_done) begin
					mop_a_q <= sum_mag;
					mop_b_q <= div_quo[SUM_W-1:0];
					acc_q   <= '0;
				end
			end
			ST_WMUL: if (pidx_q != '0) acc_q <= acc_q + pp_sh;
			default: ;
		endcase
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.divergence         = div_out_q;
	assign out_ch.zero_distance_seen = zs_out_q;
	assign out_ch.saturated          = sat_out_q;
endmodule
`default_nettype wire
